// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; included by indexed_list_store_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// Condition holds at every clock edge out of reset.
`define ASSERT_ALW(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`endif

// File: rtl/ils_pkg.sv
package ils_pkg;

	localparam int DEPTH_DEFAULT      = 64;
	localparam int DATA_WIDTH_DEFAULT = 32;
	localparam int TREE_FANIN         = 8;

	localparam int CMD_WIDTH = 3;
	localparam int POS_WIDTH = 6;
	localparam int VAL_WIDTH = 32;
	localparam int LEN_WIDTH = 7;

	localparam logic [CMD_WIDTH-1:0] CMD_APPEND    = 3'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_INSERT    = 3'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_DELETE    = 3'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_READ      = 3'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_OVERWRITE = 3'd4;

	// Broadcast to every cell; each flag is already qualified by the range and full checks.
	typedef struct packed {
		logic append;
		logic insert;
		logic remove;
		logic write;
		logic read;
	} ctl_t;

	// Number of registered levels of the read tree for n leaves.
	function automatic int tree_levels(input int n);
		int lv;
		int span;
		lv = 0;
		span = 1;
		while (span < n) begin
			span = span * TREE_FANIN;
			lv = lv + 1;
		end
		if (lv < 1) begin
			lv = 1;
		end
		return lv;
	endfunction

endpackage

// File: rtl/ils_cell.sv
module ils_cell #(
	parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEFAULT,
	parameter int PW         = ils_pkg::POS_WIDTH,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  ils_pkg::ctl_t         ctl,
	input  logic [PW-1:0]         pos,
	input  logic [PW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic [DATA_WIDTH-1:0] wdata,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_data
);

	localparam logic [PW-1:0] IDX = PW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_pos;
	logic                  above;
	logic                  at_end;

	assign at_pos = (IDX == pos);
	assign above  = (IDX > pos);
	assign at_end = (IDX == count);

	// Insert pulls the left neighbor up; delete pulls the right neighbor down.
	always_ff @(posedge clk) begin
		priority if (ctl.append && at_end) begin
			data_q <= wdata;
		end else if (ctl.insert && at_pos) begin
			data_q <= wdata;
		end else if (ctl.insert && above) begin
			data_q <= left;
		end else if (ctl.remove && (at_pos || above)) begin
			data_q <= right;
		end else if (ctl.write && at_pos) begin
			data_q <= wdata;
		end else begin
			data_q <= data_q;
		end
	end

	assign data    = data_q;
	assign rd_data = (ctl.read && at_pos) ? data_q : '0;

endmodule

// File: rtl/ils_or_tree.sv
module ils_or_tree #(
	parameter int N      = ils_pkg::DEPTH_DEFAULT,
	parameter int W      = ils_pkg::DATA_WIDTH_DEFAULT,
	parameter int LEVELS = ils_pkg::tree_levels(N)
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);

	localparam int FI = ils_pkg::TREE_FANIN;

	logic [W-1:0] node_q [LEVELS][N];

	// At most one leaf is nonzero, so an OR reduction acts as the read mux.
	always_ff @(posedge clk) begin
		logic [W-1:0] acc;
		for (int j = 0; j < N; j++) begin
			acc = '0;
			for (int k = 0; k < FI; k++) begin
				if (j * FI + k < N) begin
					acc = acc | leaf[j * FI + k];
				end
			end
			node_q[0][j] <= acc;
		end
		for (int l = 1; l < LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				acc = '0;
				for (int k = 0; k < FI; k++) begin
					if (j * FI + k < N) begin
						acc = acc | node_q[l-1][j * FI + k];
					end
				end
				node_q[l][j] <= acc;
			end
		end
	end

	assign root = node_q[LEVELS-1][0];

endmodule

// File: rtl/indexed_list_store_unit.sv
// Timing: a command is accepted on start while busy is low, and its result shows on done
// after the registered status pipeline that runs alongside the registered read tree.
// Throughput: one command per cycle while busy is low; insert and delete shift cells in the accept cycle.
// Reset: arst_n clears the element count and the done pipeline; busy stays high
// until the first edge after reset is released. Stored words, ok and length stages are not cleared.
`include "assert_macros.svh"

module indexed_list_store_unit #(
	parameter int DEPTH      = ils_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ils_pkg::CMD_WIDTH-1:0] cmd,
	input  logic [ils_pkg::POS_WIDTH-1:0] position,
	input  logic [ils_pkg::VAL_WIDTH-1:0] value,
	output logic                          done,
	output logic                          ok,
	output logic [ils_pkg::VAL_WIDTH-1:0] read_value,
	output logic [ils_pkg::LEN_WIDTH-1:0] length
);

	localparam int CW     = $clog2(DEPTH + 1);
	localparam int PW     = (CW > ils_pkg::POS_WIDTH) ? CW : ils_pkg::POS_WIDTH;
	localparam int LEVELS = ils_pkg::tree_levels(DEPTH);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic                          ready_q;
	logic                          acc;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_next;
	logic [PW-1:0]                 pos_x;
	logic [PW-1:0]                 cnt_x;
	logic                          full;
	logic                          in_range;
	logic                          ok_now;
	ils_pkg::ctl_t                 ctl;
	logic [DATA_WIDTH-1:0]         wdata;
	logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
	logic [DATA_WIDTH-1:0]         cell_rd [DEPTH];
	logic [DATA_WIDTH-1:0]         tree_root;
	logic                          done_q [LEVELS];
	logic                          ok_q [LEVELS];
	logic [ils_pkg::LEN_WIDTH-1:0] len_q [LEVELS];

	assign busy  = ~ready_q;
	assign acc   = start & ready_q;
	assign wdata = DATA_WIDTH'(value);
	assign pos_x = PW'(position);
	assign cnt_x = PW'(count_q);
	assign full  = (count_q == FULL);
	assign in_range = (pos_x < cnt_x);

	always_comb begin
		ctl = '0;
		if (acc) begin
			unique case (cmd)
				ils_pkg::CMD_APPEND: begin
					ctl.append = ~full;
				end
				ils_pkg::CMD_INSERT: begin
					ctl.insert = ~full && (pos_x <= cnt_x);
				end
				ils_pkg::CMD_DELETE: begin
					ctl.remove = in_range;
				end
				ils_pkg::CMD_READ: begin
					ctl.read = in_range;
				end
				ils_pkg::CMD_OVERWRITE: begin
					ctl.write = in_range;
				end
				default: begin
					ctl = '0;
				end
			endcase
		end
	end

	assign ok_now = ctl.append | ctl.insert | ctl.remove | ctl.read | ctl.write;

	always_comb begin
		priority if (ctl.append || ctl.insert) begin
			count_next = count_q + CW'(1);
		end else if (ctl.remove) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			count_q <= '0;
		end else begin
			ready_q <= 1'b1;
			count_q <= count_next;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_in;
		logic [DATA_WIDTH-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = wdata;
		end else begin : g_mid_l
			assign left_in = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_mid_r
			assign right_in = cell_data[i+1];
		end

		ils_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.PW        (PW),
			.INDEX     (i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.pos    (pos_x),
			.count  (cnt_x),
			.left   (left_in),
			.right  (right_in),
			.wdata  (wdata),
			.data   (cell_data[i]),
			.rd_data(cell_rd[i])
		);
	end

	ils_or_tree #(
		.N     (DEPTH),
		.W     (DATA_WIDTH),
		.LEVELS(LEVELS)
	) u_tree (
		.clk (clk),
		.leaf(cell_rd),
		.root(tree_root)
	);

	// The status of each item rides alongside the read tree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				done_q[i] <= 1'b0;
			end
		end else begin
			done_q[0] <= acc;
			for (int i = 1; i < LEVELS; i++) begin
				done_q[i] <= done_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_q[0]  <= ok_now;
		len_q[0] <= ils_pkg::LEN_WIDTH'(count_next);
		for (int i = 1; i < LEVELS; i++) begin
			ok_q[i]  <= ok_q[i-1];
			len_q[i] <= len_q[i-1];
		end
	end

	assign done       = done_q[LEVELS-1];
	assign ok         = ok_q[LEVELS-1];
	assign length     = len_q[LEVELS-1];
	assign read_value = ils_pkg::VAL_WIDTH'(tree_root);

	`ASSERT_ALW(a_count_bound, clk, arst_n, count_q <= FULL)
	`ASSERT_NXT(a_count_idle, clk, arst_n, !acc, $stable(count_q))
	`ASSERT_ALW(a_done_latency, clk, arst_n, $past(acc, LEVELS) == done)
	`ASSERT_IMP(a_read_ok, clk, arst_n, done && (read_value != '0), ok)

endmodule
